// File: sv/aip_pkg.sv
`default_nettype none
package aip_pkg;

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEX    = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_TRAIL  = 3'd5;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [35:0] LIMIT_SIGNED   = 36'h0_7FFF_FFFF;
	localparam logic [35:0] LIMIT_UNSIGNED = 36'h0_FFFF_FFFF;

	localparam int OFFSET_W = 12;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] acc;
		logic        neg;
		logic [1:0]  base;
		logic        sent;
	} state_t;

	typedef struct packed {
		logic                overflow;
		logic [OFFSET_W-1:0] rest_offset;
		logic                rest_present;
		logic [31:0]         value_bits;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase: PH_LEAD, acc: 32'd0, neg: 1'b0, base: BASE_DEC, sent: 1'b0
	};

endpackage
`default_nettype wire

// File: sv/aip_step.sv
`default_nettype none
module aip_step (
	input  wire aip_pkg::state_t                 st,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            is_last,
	input  wire logic                            signed_mode,
	input  wire logic [aip_pkg::OFFSET_W-1:0]    pos,
	output aip_pkg::state_t                      nxt,
	output logic                                 emit,
	output aip_pkg::result_t                     res
);

	aip_pkg::state_t upd;
	logic        do_add;
	logic        do_trail;
	logic [3:0]  digit;
	logic        is_dec;
	logic        is_hex;
	logic        is_space;
	logic [3:0]  hex_val;
	logic [35:0] acc_w;
	logic [35:0] prod;
	logic [35:0] lim;
	logic        ovf;
	logic        rest;

	always_comb begin
		is_dec   = (char_code >= "0") && (char_code <= "9");
		is_space = char_code inside {8'd32, [8'd9:8'd13]};
		is_hex   = 1'b1;
		hex_val  = 4'd0;
		if (is_dec) begin
			hex_val = 4'(char_code - "0");
		end else if (char_code inside {["A":"F"]}) begin
			hex_val = 4'(char_code - "A" + 8'd10);
		end else if (char_code inside {["a":"f"]}) begin
			hex_val = 4'(char_code - "a" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		upd      = st;
		do_add   = 1'b0;
		do_trail = 1'b0;
		digit    = 4'(char_code - "0");
		emit     = 1'b0;
		ovf      = 1'b0;
		rest     = 1'b0;
		if (!st.sent) begin
			case (st.phase)
				aip_pkg::PH_ZERO: begin
					if (char_code == "x" || char_code == "X") begin
						upd.base  = aip_pkg::BASE_HEX;
						upd.phase = aip_pkg::PH_HEX;
					end else begin
						upd.phase = aip_pkg::PH_DIGITS;
						do_add    = is_dec;
						do_trail  = !is_dec;
					end
				end
				aip_pkg::PH_HEX: begin
					digit    = hex_val;
					do_add   = is_hex;
					do_trail = !is_hex;
				end
				aip_pkg::PH_DIGITS: begin
					do_add   = is_dec;
					do_trail = !is_dec;
				end
				aip_pkg::PH_TRAIL: begin
					do_trail = 1'b1;
				end
				default: begin
					// leading skip, after a sign, and unused codes
					if (char_code == "0") begin
						upd.base  = aip_pkg::BASE_OCT;
						upd.phase = aip_pkg::PH_ZERO;
					end else if (is_dec) begin
						upd.base  = aip_pkg::BASE_DEC;
						upd.phase = aip_pkg::PH_DIGITS;
						do_add    = 1'b1;
					end else if (st.phase == aip_pkg::PH_SIGNED) begin
						do_trail = 1'b1;
					end else if (char_code == 8'd0) begin
						emit = 1'b1;
					end else if (char_code == "+") begin
						upd.phase = aip_pkg::PH_SIGNED;
					end else if (char_code == "-") begin
						upd.neg   = 1'b1;
						upd.phase = aip_pkg::PH_SIGNED;
					end
				end
			endcase
		end

		// multiply by base as shifts and add
		acc_w = {4'd0, st.acc};
		case (upd.base)
			aip_pkg::BASE_HEX: prod = acc_w << 4;
			aip_pkg::BASE_OCT: prod = acc_w << 3;
			default:           prod = (acc_w << 3) + (acc_w << 1);
		endcase
		prod = prod + {32'd0, digit};
		lim  = signed_mode ? aip_pkg::LIMIT_SIGNED : aip_pkg::LIMIT_UNSIGNED;

		if (do_add) begin
			if (prod > lim) begin
				upd.acc = lim[31:0];
				ovf     = 1'b1;
				emit    = 1'b1;
			end else begin
				upd.acc = prod[31:0];
			end
		end

		if (do_trail) begin
			upd.phase = aip_pkg::PH_TRAIL;
			if (!is_space) begin
				emit = 1'b1;
				rest = (char_code != 8'd0);
			end
		end

		// string end without a result yet
		if (is_last && !st.sent && !emit) begin
			emit = 1'b1;
		end
		if (emit) begin
			upd.sent = 1'b1;
		end

		res.value_bits   = upd.neg ? (32'd0 - upd.acc) : upd.acc;
		res.rest_present = rest;
		res.rest_offset  = rest ? pos : '0;
		res.overflow     = ovf;

		nxt = is_last ? aip_pkg::STATE_RESET : upd;
	end

endmodule
`default_nettype wire

// File: sv/ascii_integer_parser.sv
// Path: a character transferred into the input register waits there until the result
//   slot is free or being drained; its result then enters the output register.
// Throughput: one character per cycle unless a held result stalls the input stage.
// Reset (arst_n low, asynchronous): parser returns to the leading skip phase, position 0,
//   signed_mode 1, both handshake stages empty.
`default_nettype none
module ascii_integer_parser #(
	parameter int MAX_STRING_LEN = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: signed_mode
	input  wire logic        cfg_wen,
	input  wire logic        cfg_wdata,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_last
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // [31:0] value_bits, [32] rest_present,
	                                    // [44:33] rest_offset, [45] overflow, [47:46] zero
);

	localparam int PW = $clog2(MAX_STRING_LEN);
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_STRING_LEN - 1);

	// input register stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parse state
	aip_pkg::state_t state_q;
	aip_pkg::state_t state_nxt;
	logic [PW-1:0]   pos_q;
	logic            signed_q;

	// result register
	logic             m_valid_q;
	aip_pkg::result_t res_q;
	aip_pkg::result_t res_nxt;
	logic             emit;

	logic                            advance;
	logic                            s_xfer;
	logic [PW+aip_pkg::OFFSET_W-1:0] pos_ext;

	// The input stage moves on whenever the result slot is free or being drained.
	// A result held by the receiver stalls the input stage and, through it, s_tready.
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_xfer   = s_tvalid && s_tready;

	// rest_offset is the low bits of the position, zero-extended for short strings
	assign pos_ext = {{aip_pkg::OFFSET_W{1'b0}}, pos_q};

	aip_step u_step (
		.st          (state_q),
		.char_code   (char_s1),
		.is_last     (last_s1),
		.signed_mode (signed_q),
		.pos         (pos_ext[aip_pkg::OFFSET_W-1:0]),
		.nxt         (state_nxt),
		.emit        (emit),
		.res         (res_nxt)
	);

	// configuration register; the user writes it only while the parser is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
		end else if (cfg_wen) begin
			signed_q <= cfg_wdata;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload: hold until consumed
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parse state and position; the last character of a string clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aip_pkg::STATE_RESET;
			pos_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			if (last_s1 || pos_q == POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// result slot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res_q};

	// an overflow ends the number with no rest
	a_ovf_no_rest: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(res_q.overflow && res_q.rest_present))
		else $error("overflow result carries a rest");

	// offset is zero when no rest follows
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !res_q.rest_present) |-> (res_q.rest_offset == '0))
		else $error("rest_offset nonzero without rest");

	// the last character restarts the string state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (!state_q.sent && pos_q == '0
			&& state_q.phase == aip_pkg::PH_LEAD))
		else $error("string state not cleared after last character");

	// a string whose result was sent gives no further result before its end
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.sent) |-> !emit)
		else $error("second result for one string");

endmodule
`default_nettype wire

// File: bench/aip_monitor.sv
`default_nettype none
module aip_monitor
	import aip_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_last
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,   // [31:0] value_bits, [32] rest_present,
	                                    // [44:33] rest_offset, [45] overflow
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// parser state as the block should hold it
	logic                signed_lim;
	logic [2:0]          phase;
	logic [31:0]         acc;
	logic                neg;
	logic [1:0]          base;
	logic [OFFSET_W-1:0] pos;
	logic                sent;

	result_t expected_numbers[$];
	int      mismatches;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// 16 means not a hex digit
	function automatic logic [4:0] hex_digit_value(logic [7:0] c);
		if (is_digit(c))
			return 5'(c - "0");
		if (c >= "A" && c <= "F")
			return 5'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f")
			return 5'(c - "a" + 8'd10);
		return 5'd16;
	endfunction

	function automatic result_t make_number(logic rest, logic [OFFSET_W-1:0] off, logic ovf);
		result_t r;
		r.value_bits   = neg ? (32'd0 - acc) : acc;
		r.rest_present = rest;
		r.rest_offset  = rest ? off : '0;
		r.overflow     = ovf;
		return r;
	endfunction

	task automatic clear_string();
		phase = PH_LEAD;
		acc   = '0;
		neg   = 1'b0;
		base  = BASE_DEC;
		pos   = '0;
		sent  = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last,
	                          output logic fire, output result_t r);
		logic        dig;
		logic        to_trail;
		logic [3:0]  dv;
		logic [4:0]  hv;
		logic [35:0] mult;
		logic [35:0] wide;
		logic [35:0] lim;
		fire     = 1'b0;
		dig      = 1'b0;
		to_trail = 1'b0;
		dv       = '0;
		r        = '0;
		if (!sent) begin
			if (phase == PH_LEAD || phase == PH_SIGNED) begin
				if (c == "0") begin
					base  = BASE_OCT;
					phase = PH_ZERO;
				end else if (is_digit(c)) begin
					base  = BASE_DEC;
					phase = PH_DIGITS;
					dig   = 1'b1;
					dv    = 4'(c - "0");
				end else if (phase == PH_SIGNED) begin
					to_trail = 1'b1;
				end else if (c == 8'd0) begin
					fire = 1'b1;
					r    = make_number(1'b0, '0, 1'b0);
				end else if (c == "+") begin
					phase = PH_SIGNED;
				end else if (c == "-") begin
					neg   = 1'b1;
					phase = PH_SIGNED;
				end
			end else if (phase != PH_TRAIL) begin
				if (phase == PH_ZERO && (c == "x" || c == "X")) begin
					base  = BASE_HEX;
					phase = PH_HEX;
				end else begin
					if (phase == PH_ZERO)
						phase = PH_DIGITS;
					if (phase == PH_HEX) begin
						hv = hex_digit_value(c);
						if (hv < 5'd16) begin
							dig = 1'b1;
							dv  = hv[3:0];
						end else begin
							to_trail = 1'b1;
						end
					end else if (is_digit(c)) begin
						dig = 1'b1;
						dv  = 4'(c - "0");
					end else begin
						to_trail = 1'b1;
					end
				end
			end else begin
				to_trail = 1'b1;
			end

			if (dig) begin
				mult = (base == BASE_HEX) ? 36'd16 : ((base == BASE_OCT) ? 36'd8 : 36'd10);
				lim  = signed_lim ? LIMIT_SIGNED : LIMIT_UNSIGNED;
				wide = {4'd0, acc} * mult + {32'd0, dv};
				if (wide > lim) begin
					acc  = lim[31:0];
					fire = 1'b1;
					r    = make_number(1'b0, '0, 1'b1);
				end else begin
					acc = wide[31:0];
				end
			end
			if (to_trail) begin
				phase = PH_TRAIL;
				if (!is_blank(c)) begin
					fire = 1'b1;
					r    = make_number(c != 8'd0, pos, 1'b0);
				end
			end
			if (fire)
				sent = 1'b1;
		end
		if (last) begin
			if (!sent) begin
				fire = 1'b1;
				r    = make_number(1'b0, '0, 1'b0);
			end
			clear_string();
		end else begin
			pos = pos + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		result_t r;
		logic    fire;
		if (!arst_n) begin
			signed_lim = 1'b1;
			clear_string();
			expected_numbers.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wen)
				signed_lim = cfg_wdata;

			// compare before predicting so a same-edge input never matches
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[45:0]);
				if (expected_numbers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h rest %b off %0d ovf %b",
						         got.value_bits, got.rest_present, got.rest_offset,
						         got.overflow);
				end else begin
					want = expected_numbers.pop_front();
					if (got.value_bits !== want.value_bits ||
					    got.rest_present !== want.rest_present ||
					    got.rest_offset !== want.rest_offset ||
					    got.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected value %h rest %b off %0d ovf %b,",
							          " got value %h rest %b off %0d ovf %b"},
							         want.value_bits, want.rest_present, want.rest_offset,
							         want.overflow, got.value_bits, got.rest_present,
							         got.rest_offset, got.overflow);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, s_tlast, fire, r);
				if (fire)
					expected_numbers.push_back(r);
			end

			fail_count <= mismatches;
			pending    <= expected_numbers.size();
		end
	end

endmodule
`default_nettype wire

// File: bench/tb_ascii_integer_parser.sv
`default_nettype none
module tb_ascii_integer_parser;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	int          fail_count;
	int          pending;

	// characters of the string being built, sent as one run
	logic [7:0]  str_buf[$];
	int          items_sent;
	// hold the sender steady (no gaps) while set
	logic        tx_steady;

	always #2 clk = ~clk;

	ascii_integer_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	aip_monitor parse_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one character and hold it until the transfer edge. Gaps lower
	// tvalid first; back-to-back items keep it high across edges.
	task automatic send_char(input logic [7:0] c, input logic last);
		while (!tx_steady && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		tx_steady = (items_sent >= 700 && items_sent < 1100);
	endtask

	// Send the buffered string, tlast on its final character, then drop it.
	task automatic send_buf();
		for (int i = 0; i < str_buf.size(); i++)
			send_char(str_buf[i], i == str_buf.size() - 1);
		str_buf.delete();
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			str_buf.push_back(s[i]);
	endtask

	// Drop tvalid and wait until every expected number has arrived, then let
	// the two pipeline stages settle before touching the register.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Mostly well-formed numbers with random sign, base, length and tail;
	// the rest is raw bytes of any value.
	task automatic build_random_string();
		int    n_dig;
		int    pick;
		string junk;
		string hexdig;
		junk   = " \t\n#az=~";
		hexdig = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 99) < 20) begin
			repeat ($urandom_range(1, 8)) str_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2))
				str_buf.push_back(junk[$urandom_range(0, junk.len() - 1)]);
			pick = $urandom_range(0, 2);
			if (pick == 1)
				str_buf.push_back("+");
			else if (pick == 2)
				str_buf.push_back("-");
			// long digit runs can push past the limit in either mode
			n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
			pick  = $urandom_range(0, 2);
			if (pick == 0) begin
				if (n_dig > 0) begin
					str_buf.push_back(8'("1" + $urandom_range(0, 8)));
					repeat (n_dig - 1) str_buf.push_back(8'("0" + $urandom_range(0, 9)));
				end
			end else if (pick == 1) begin
				// octal run, 8 and 9 included
				str_buf.push_back("0");
				repeat (n_dig) str_buf.push_back(8'("0" + $urandom_range(0, 9)));
			end else begin
				str_buf.push_back("0");
				str_buf.push_back($urandom_range(0, 1) ? "x" : "X");
				repeat (n_dig) str_buf.push_back(hexdig[$urandom_range(0, 21)]);
			end
			repeat ($urandom_range(0, 2)) str_buf.push_back($urandom_range(0, 1) ? " " : "\t");
			pick = $urandom_range(0, 3);
			if (pick == 1) begin
				str_buf.push_back(8'("g" + $urandom_range(0, 19)));
				repeat ($urandom_range(0, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
			end else if (pick == 2) begin
				str_buf.push_back(8'd0);
				repeat ($urandom_range(0, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
			end else if (pick == 3) begin
				repeat ($urandom_range(1, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (str_buf.size() == 0)
			str_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Receiver: random stalls, one long hold-off so the block backs up into
	// its input, and one stretch that never stalls.
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= 1000 && rx_cycle < 1300)
				m_tready <= 1'b0;
			else if (rx_cycle >= 1600 && rx_cycle < 2100)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 9);
		end
	end

	// Stimulus and verdict.
	initial begin
		int target;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_wdata  = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		items_sent = 0;
		tx_steady  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings in signed mode
		write_mode(1'b1);
		put_text("-12 a");      // sign, decimal, blank, then a rest
		send_buf();
		put_text("0x1F");       // hex, ended by tlast
		send_buf();
		put_text("+07");        // plus sign, octal
		send_buf();
		put_text("089");        // octal prefix still takes 8 and 9
		send_buf();
		str_buf.push_back(8'd0); // NUL before any digit
		send_buf();
		put_text("- 7");        // sign with no digits, rest after blank
		send_buf();
		put_text("3000000000"); // past the signed limit
		send_buf();
		str_buf.push_back(8'hFF); // skipped character, string ends empty
		send_buf();

		// random phases, alternating the limit mode
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_mode(p % 2 == 1);
			target = 60 + (p + 1) * 282;
			while (items_sent < target) begin
				build_random_string();
				send_buf();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
